@@ rtl/core/bit_length_codec_decoder_unit_macros.svh @@
// assertion macros shared by the bit-length decoder rtl
// no dependencies; included by the modules that carry checks
`ifndef BIT_LENGTH_CODEC_DECODER_UNIT_MACROS_SVH
`define BIT_LENGTH_CODEC_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define BLDEC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check
`define BLDEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BLDEC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define BLDEC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/bldec_pkg.sv @@
// shared types and constants of the bit-length decoder
// no dependencies
`default_nettype none

package bldec_pkg;

  // widths fixed by the field definitions
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 24;
  localparam int unsigned EXT_W   = 6;
  localparam int unsigned BITS_W  = 6;
  localparam int unsigned NIB_W   = 4;
  localparam int unsigned FW_W    = 7;

  // nibble coding limits
  localparam logic [NIB_W-1:0] NIBBLE_MAX = 4'd8;
  localparam logic [BITS_W-1:0] NIBBLE_BITS = 6'd4;

  // width saturation bounds
  localparam logic signed [7:0] WIDTH_HI = 8'sd32;
  localparam logic signed [7:0] WIDTH_LO = -8'sd64;

  // defaults of the block header field sizes
  localparam int unsigned BLOCK_FIELD_BITS_DEF = 4;
  localparam int unsigned RUN_LENGTH_BITS_DEF  = 4;

  // result request queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one result request: raw field, sign-extension width (0 means none), base to add
  typedef struct packed {
    logic [VALUE_W-1:0] raw;
    logic [EXT_W-1:0]   ext_width;
    logic [VALUE_W-1:0] offset;
    logic               last;
    logic               err;
  } res_req_t;

endpackage

`default_nettype wire

@@ rtl/core/bldec_front.sv @@
// stream parser: takes one bit per cycle while in_stall is low, tracks the header
// and field state and pushes a request per value up to value_count; depends on bldec_pkg
`default_nettype none
`include "bit_length_codec_decoder_unit_macros.svh"

module bldec_front #(
  parameter int unsigned BLOCK_FIELD_BITS = bldec_pkg::BLOCK_FIELD_BITS_DEF,
  parameter int unsigned RUN_LENGTH_BITS  = bldec_pkg::RUN_LENGTH_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            stream_bit,
  input  wire logic                            cfg_write,
  input  wire logic [bldec_pkg::COUNT_W-1:0]   cfg_count,
  input  wire logic                            q_full,
  output logic                                 push,
  output bldec_pkg::res_req_t                  req
);

  typedef enum logic [3:0] {
    PH_TAG,
    PH_FIRST_DATA,
    PH_FIRST_MORE,
    PH_SECOND_DATA,
    PH_SECOND_MORE,
    PH_FIX_VALUE,
    PH_DELTA,
    PH_RUNLEN,
    PH_RUN_VALUE,
    PH_SIZE
  } phase_t;

  localparam logic [BLOCK_FIELD_BITS-1:0] DELTA_MIN = {1'b1, {(BLOCK_FIELD_BITS-1){1'b0}}};
  localparam logic [BLOCK_FIELD_BITS-1:0] DELTA_MAX = {1'b0, {(BLOCK_FIELD_BITS-1){1'b1}}};

  // state
  phase_t                             phase, phase_next;
  logic                               variable_mode, variable_mode_next;
  logic [bldec_pkg::VALUE_W-1:0]      bit_shift, bit_shift_next;
  logic [bldec_pkg::BITS_W-1:0]       bits_in_field, bits_in_field_next;
  logic [bldec_pkg::NIB_W-1:0]        nibble_index, nibble_index_next;
  logic [bldec_pkg::VALUE_W-1:0]      first_bound, first_bound_next;
  logic [bldec_pkg::VALUE_W-1:0]      offset_base, offset_base_next;
  logic signed [bldec_pkg::FW_W-1:0]  field_width, field_width_next;
  logic [RUN_LENGTH_BITS-1:0]         run_remaining, run_remaining_next;
  logic [bldec_pkg::COUNT_W-1:0]      values_emitted, values_emitted_next;
  logic                               error_seen, error_seen_next;
  logic [bldec_pkg::COUNT_W-1:0]      value_count;

  // helpers
  logic                               step;
  logic [bldec_pkg::VALUE_W-1:0]      shift_in;
  logic [bldec_pkg::BITS_W-1:0]       bits_inc;
  logic [bldec_pkg::COUNT_W-1:0]      ve_inc;
  logic                               done_now;
  logic                               done_inc;
  logic                               fw_pos;
  logic [4:0]                         nib_pos;
  logic [bldec_pkg::NIB_W-1:0]        nib_count;
  logic [bldec_pkg::BITS_W-1:0]       nib_bits;
  logic [bldec_pkg::VALUE_W-1:0]      nib_mask;
  logic [bldec_pkg::VALUE_W-1:0]      nib_value;
  logic [BLOCK_FIELD_BITS-1:0]        delta_raw;
  logic signed [7:0]                  delta_ext;
  logic signed [7:0]                  width_sum;
  logic                               emit_now;
  logic [RUN_LENGTH_BITS-1:0]         run_dec;

  // number of significant bits of a word: per-byte search, then pick the top byte
  function automatic logic [bldec_pkg::EXT_W-1:0] bit_size(input logic [31:0] x);
    logic [3:0]      nz;
    logic [2:0]      hi [4];
    logic [5:0]      n;
    n = '0;
    for (int g = 0; g < 4; g++) begin
      nz[g] = |x[8*g +: 8];
      hi[g] = '0;
      for (int j = 0; j < 8; j++) begin
        if (x[8*g + j]) hi[g] = 3'(j);
      end
    end
    for (int g = 0; g < 4; g++) begin
      if (nz[g]) n = {1'b0, 2'(g), hi[g]} + 6'd1;
    end
    return n;
  endfunction

  assign step     = (in_valid && !in_stall) || (phase == PH_SIZE);
  assign in_stall = q_full || (phase == PH_SIZE);

  assign shift_in = {bit_shift[bldec_pkg::VALUE_W-2:0], stream_bit};
  assign bits_inc = bits_in_field + 1'b1;
  assign ve_inc   = values_emitted + 1'b1;
  assign done_now = values_emitted >= value_count;
  assign done_inc = ve_inc >= value_count;
  assign fw_pos   = !field_width[bldec_pkg::FW_W-1] && (field_width != '0);

  // nibble bit position: least significant nibble first, msb first inside it
  assign nib_pos = {nibble_index[2:0], ~bits_in_field[1:0]};

  // sign extension of the nibble-coded value from its nibble count
  assign nib_count = (nibble_index >= bldec_pkg::NIBBLE_MAX) ? bldec_pkg::NIBBLE_MAX
                                                             : nibble_index + 1'b1;
  assign nib_bits  = {nib_count, 2'b00};
  assign nib_mask  = {bldec_pkg::VALUE_W{1'b1}} << nib_bits;
  assign nib_value = bit_shift[5'(nib_bits - 6'd1)] ? (bit_shift | nib_mask) : bit_shift;

  // width delta of a block header
  assign delta_raw = shift_in[BLOCK_FIELD_BITS-1:0];
  assign delta_ext = 8'(signed'(delta_raw));
  assign width_sum = 8'(field_width) + delta_ext;
  assign run_dec   = run_remaining - 1'b1;

  // next-state logic of the parser
  always_comb begin
    phase_next          = phase;
    variable_mode_next  = variable_mode;
    bit_shift_next      = bit_shift;
    bits_in_field_next  = bits_in_field;
    nibble_index_next   = nibble_index;
    first_bound_next    = first_bound;
    offset_base_next    = offset_base;
    field_width_next    = field_width;
    run_remaining_next  = run_remaining;
    values_emitted_next = values_emitted;
    error_seen_next     = error_seen;
    emit_now            = 1'b0;
    push                = 1'b0;
    req                 = '0;
    req.offset          = offset_base;
    req.err             = error_seen;
    req.last            = done_inc;
    if (step) begin
      unique case (phase) inside
        PH_TAG: begin
          variable_mode_next  = stream_bit;
          values_emitted_next = '0;
          error_seen_next     = 1'b0;
          field_width_next    = '0;
          bit_shift_next      = '0;
          bits_in_field_next  = '0;
          nibble_index_next   = '0;
          phase_next          = PH_FIRST_DATA;
        end
        PH_FIRST_DATA, PH_SECOND_DATA: begin
          if (nibble_index < bldec_pkg::NIBBLE_MAX) begin
            bit_shift_next = bit_shift | (bldec_pkg::VALUE_W'(stream_bit) << nib_pos);
          end else begin
            error_seen_next = 1'b1;
          end
          bits_in_field_next = bits_inc;
          if (bits_inc >= bldec_pkg::NIBBLE_BITS) begin
            phase_next = (phase == PH_FIRST_DATA) ? PH_FIRST_MORE : PH_SECOND_MORE;
          end
        end
        PH_FIRST_MORE, PH_SECOND_MORE: begin
          if (stream_bit) begin
            if (nibble_index < bldec_pkg::NIBBLE_MAX) nibble_index_next = nibble_index + 1'b1;
            bits_in_field_next = '0;
            phase_next = (phase == PH_FIRST_MORE) ? PH_FIRST_DATA : PH_SECOND_DATA;
          end else if (phase == PH_FIRST_MORE) begin
            bit_shift_next     = '0;
            bits_in_field_next = '0;
            nibble_index_next  = '0;
            if (variable_mode) begin
              offset_base_next = nib_value;
              field_width_next = '0;
              phase_next       = done_now ? PH_TAG : PH_DELTA;
            end else begin
              first_bound_next = nib_value;
              phase_next       = PH_SECOND_DATA;
            end
          end else begin
            // range of the fixed field, sized in the next cycle
            bit_shift_next     = nib_value - first_bound;
            bits_in_field_next = '0;
            nibble_index_next  = '0;
            phase_next         = PH_SIZE;
          end
        end
        PH_SIZE: begin
          offset_base_next   = first_bound;
          field_width_next   = signed'(bldec_pkg::FW_W'(bit_size(bit_shift)));
          bit_shift_next     = '0;
          bits_in_field_next = '0;
          nibble_index_next  = '0;
          phase_next         = done_now ? PH_TAG : PH_FIX_VALUE;
        end
        PH_FIX_VALUE: begin
          emit_now = 1'b1;
          if (fw_pos) begin
            bit_shift_next     = shift_in;
            bits_in_field_next = bits_inc;
            if (bits_inc < bldec_pkg::BITS_W'(field_width)) emit_now = 1'b0;
          end
          if (emit_now) begin
            push                = 1'b1;
            req.raw             = fw_pos ? shift_in : bit_shift;
            req.ext_width       = '0;
            values_emitted_next = ve_inc;
            bit_shift_next      = '0;
            bits_in_field_next  = '0;
            nibble_index_next   = '0;
            if (done_inc) phase_next = PH_TAG;
          end
        end
        PH_DELTA: begin
          bit_shift_next     = shift_in;
          bits_in_field_next = bits_inc;
          if (bits_inc >= bldec_pkg::BITS_W'(BLOCK_FIELD_BITS)) begin
            if (width_sum > bldec_pkg::WIDTH_HI) begin
              field_width_next = bldec_pkg::FW_W'(bldec_pkg::WIDTH_HI);
              error_seen_next  = 1'b1;
            end else if (width_sum < bldec_pkg::WIDTH_LO) begin
              field_width_next = bldec_pkg::FW_W'(bldec_pkg::WIDTH_LO);
            end else begin
              field_width_next = bldec_pkg::FW_W'(width_sum);
            end
            bit_shift_next     = '0;
            bits_in_field_next = '0;
            nibble_index_next  = '0;
            if (delta_raw != DELTA_MIN && delta_raw != DELTA_MAX) phase_next = PH_RUNLEN;
          end
        end
        PH_RUNLEN: begin
          bit_shift_next     = shift_in;
          bits_in_field_next = bits_inc;
          if (bits_inc >= bldec_pkg::BITS_W'(RUN_LENGTH_BITS)) begin
            run_remaining_next = shift_in[RUN_LENGTH_BITS-1:0];
            bit_shift_next     = '0;
            bits_in_field_next = '0;
            nibble_index_next  = '0;
            if (shift_in[RUN_LENGTH_BITS-1:0] == '0) begin
              phase_next = done_now ? PH_TAG : PH_DELTA;
            end else begin
              phase_next = PH_RUN_VALUE;
            end
          end
        end
        PH_RUN_VALUE: begin
          emit_now = 1'b1;
          if (fw_pos) begin
            bit_shift_next     = shift_in;
            bits_in_field_next = bits_inc;
            if (bits_inc < bldec_pkg::BITS_W'(field_width)) emit_now = 1'b0;
          end
          if (emit_now) begin
            // surplus run values are read and dropped
            push          = !done_now;
            req.raw       = fw_pos ? shift_in : '0;
            req.ext_width = fw_pos ? bldec_pkg::EXT_W'(field_width) : '0;
            if (!done_now) values_emitted_next = ve_inc;
            bit_shift_next     = '0;
            bits_in_field_next = '0;
            nibble_index_next  = '0;
            run_remaining_next = run_dec;
            if (run_dec == '0) begin
              phase_next = ((!done_now && done_inc) || done_now) ? PH_TAG : PH_DELTA;
            end
          end
        end
        default: begin
          phase_next = PH_TAG;
        end
      endcase
    end
  end

  // state registers and the value count register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TAG;
      variable_mode  <= 1'b0;
      bit_shift      <= '0;
      bits_in_field  <= '0;
      nibble_index   <= '0;
      first_bound    <= '0;
      offset_base    <= '0;
      field_width    <= '0;
      run_remaining  <= '0;
      values_emitted <= '0;
      error_seen     <= 1'b0;
      value_count    <= bldec_pkg::COUNT_W'(1);
    end else begin
      phase          <= phase_next;
      variable_mode  <= variable_mode_next;
      bit_shift      <= bit_shift_next;
      bits_in_field  <= bits_in_field_next;
      nibble_index   <= nibble_index_next;
      first_bound    <= first_bound_next;
      offset_base    <= offset_base_next;
      field_width    <= field_width_next;
      run_remaining  <= run_remaining_next;
      values_emitted <= values_emitted_next;
      error_seen     <= error_seen_next;
      if (cfg_write) value_count <= cfg_count;
    end
  end

  // checks
  `BLDEC_ASSERT_NEXT(a_size_one_cycle, clk, rst, phase == PH_SIZE, phase != PH_SIZE, "sizing cycle repeated")
  `BLDEC_ASSERT_NOW(a_push_only_on_value, clk, rst, push, phase == PH_FIX_VALUE || phase == PH_RUN_VALUE, "request outside a value field")

endmodule

`default_nettype wire

@@ rtl/core/bldec_queue.sv @@
// short fifo of result requests between the parser and the output stage
// depends on bldec_pkg
`default_nettype none
`include "bit_length_codec_decoder_unit_macros.svh"

module bldec_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bldec_pkg::res_req_t push_req,
  input  wire logic                pop,
  output bldec_pkg::res_req_t      head,
  output logic                     nonempty,
  output logic                     full
);

  localparam logic [bldec_pkg::QPTR_W-1:0] LAST_SLOT =
    bldec_pkg::QPTR_W'(bldec_pkg::QUEUE_DEPTH - 1);
  localparam logic [bldec_pkg::QCNT_W-1:0] DEPTH_CNT =
    bldec_pkg::QCNT_W'(bldec_pkg::QUEUE_DEPTH);

  bldec_pkg::res_req_t               slots [bldec_pkg::QUEUE_DEPTH];
  logic [bldec_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bldec_pkg::QPTR_W-1:0]      rd_ptr;
  logic [bldec_pkg::QCNT_W-1:0]      count;
  logic                              do_push;
  logic                              do_pop;

  assign nonempty = (count != '0);
  assign full     = (count == DEPTH_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = slots[rd_ptr];

  // request storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_req;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // checks
  `BLDEC_ASSERT_NOW(a_no_push_when_full, clk, rst, push, !full, "request pushed into full queue")
  `BLDEC_ASSERT_NEXT(a_pop_frees_slot, clk, rst, full && pop && !push, !full, "pop did not free a slot")

endmodule

`default_nettype wire

@@ rtl/core/bldec_back.sv @@
// output stage: sign-extends the raw field, adds the base and holds the result
// in the output register; depends on bldec_pkg
`default_nettype none
`include "bit_length_codec_decoder_unit_macros.svh"

module bldec_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bldec_pkg::res_req_t               head,
  input  wire logic                              nonempty,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bldec_pkg::VALUE_W-1:0]   value_out,
  output logic                                   last_value,
  output logic                                   format_error
);

  logic [bldec_pkg::VALUE_W-1:0] ext_mask;
  logic [4:0]                    sign_idx;
  logic                          do_ext;
  logic [bldec_pkg::VALUE_W-1:0] ext_value;
  logic [bldec_pkg::VALUE_W-1:0] sum;

  // sign extension at the requested width
  assign do_ext    = (head.ext_width != '0) &&
                     (head.ext_width < bldec_pkg::EXT_W'(bldec_pkg::VALUE_W));
  assign sign_idx  = 5'(head.ext_width - 1'b1);
  assign ext_mask  = {bldec_pkg::VALUE_W{1'b1}} << head.ext_width;
  assign ext_value = !do_ext           ? head.raw :
                     head.raw[sign_idx] ? (head.raw | ext_mask) : (head.raw & ~ext_mask);
  assign sum       = ext_value + head.offset;

  // load when the output register is empty or being taken
  assign pop = nonempty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      value_out    <= signed'(sum);
      last_value   <= head.last;
      format_error <= head.err;
    end
  end

  // checks
  `BLDEC_ASSERT_NEXT(a_request_reaches_output, clk, rst, nonempty && !out_valid, out_valid, "pending request not loaded")

endmodule

`default_nettype wire

@@ rtl/core/bit_length_codec_decoder_unit.sv @@
// top level of the bit-length decoder: parser, request queue, output stage
// depends on bldec_pkg, bldec_front, bldec_queue, bldec_back
`default_nettype none

// Decodes a bit-length coded stream fed one bit per cycle while in_stall is low,
// most significant bit first in each field and nibble, nibbles least significant
// first. A tag bit starts each decode (0 fixed range, 1 variable blocks); each
// decode gives value_count values, the last one marked, with format_error set
// once a width above 32 or a ninth nibble was seen. in_stall is high after the
// max field of a fixed-mode header, where the bit-length search sizes the range,
// and while the request queue is full. Results pass a two-entry request queue and
// a registered adder stage. The parser keeps taking bits while up to two results
// wait on out_stall; a third waiting result fills the queue and raises in_stall.
// value_count is written over the cfg channel (always ready); the user must write
// it only while no decode is in flight, as the block does not enforce this.
module bit_length_codec_decoder_unit #(
  parameter int unsigned BLOCK_FIELD_BITS = bldec_pkg::BLOCK_FIELD_BITS_DEF,
  parameter int unsigned RUN_LENGTH_BITS  = bldec_pkg::RUN_LENGTH_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              stream_bit,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bldec_pkg::VALUE_W-1:0]   value_out,
  output logic                                   last_value,
  output logic                                   format_error,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bldec_pkg::COUNT_W-1:0]     value_count
);

  logic                q_full;
  logic                q_nonempty;
  logic                push;
  logic                pop;
  bldec_pkg::res_req_t req;
  bldec_pkg::res_req_t head;

  assign cfg_ready = 1'b1;

  // stream parser
  bldec_front #(
    .BLOCK_FIELD_BITS (BLOCK_FIELD_BITS),
    .RUN_LENGTH_BITS  (RUN_LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .stream_bit (stream_bit),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_count  (value_count),
    .q_full     (q_full),
    .push       (push),
    .req        (req)
  );

  // request queue
  bldec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (req),
    .pop      (pop),
    .head     (head),
    .nonempty (q_nonempty),
    .full     (q_full)
  );

  // output stage
  bldec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .nonempty     (q_nonempty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value_out    (value_out),
    .last_value   (last_value),
    .format_error (format_error)
  );

endmodule

`default_nettype wire
